// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: widths, codes, cell entry type.
// No dependencies.
package ffha_pkg;
   localparam int ADDR_W = 25;
   localparam int SIZE_W = 26;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO     = 2'd1,
      ST_NO_FIT   = 2'd2,
      ST_BAD_FREE = 2'd3
   } status_type;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              used;
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } entry_type;
endpackage

// ===== rtl/ffha_cell.sv =====
// One table cell: holds one entry; takes its shift input each cycle, forming one link of a chain.
// Depends on ffha_pkg.
module ffha_cell
   import ffha_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load_reset,
   input  entry_type reset_val,
   input  entry_type shift_in,
   output entry_type held
);
   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = load_reset ? reset_val : shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= reset_val;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign held = entry_ff;
endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with merging of free neighbors.
// A request runs a pass through the table in S_RUN and replies in S_DONE; a zero-size
// allocate skips the pass and goes straight to S_DONE. Busy stays high until the reply is out,
// so a new request word is taken only after the last reply. The block table is a chain of
// MAX_BLOCKS cells that turns once per request other than a zero-size allocate. Synchronous
// reset leaves one free block covering the heap. Replies cannot be stalled.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int HEAP_BYTES   = 33554432
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_req_type,
   input  logic [SIZE_W-1:0] req_alloc_size,
   input  logic [ADDR_W-1:0] req_free_addr,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_payload_addr,
   output logic [1:0]        rsp_status
);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int NW = SIZE_W + 1;
   localparam logic [NW-1:0] HDR  = NW'(HEADER_BYTES);
   localparam logic [CW-1:0] FULL = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] LAST = CW'(MAX_BLOCKS - 1);
   localparam entry_type INIT_ENTRY = {1'b1, 1'b0, {ADDR_W{1'b0}}, SIZE_W'(HEAP_BYTES)};

   // Pass plan: during S_RUN the chain shifts one place toward cell 0 every cycle and the
   // entry built from the head taps enters at the last cell, so after a full pass the
   // rebuilt table sits in place again. Step t rebuilds table index t.
   //  - split: the free remainder waits in a carry register; each later entry is delayed by
   //    one place and the first empty slot absorbs the delay.
   //  - merge: entries dropped by a merge are skipped by reading a later tap (skip 1 or 2).
   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_type;

   state_type         state_ff;
   logic              op_ff;
   logic [NW-1:0]     need_ff;       // request plus one header
   logic [ADDR_W-1:0] faddr_ff;
   logic              done_ff;       // block granted / freed block rebuilt
   logic [1:0]        skip_ff;       // entries dropped by the merge so far
   logic [CW-1:0]     step_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     newcount_ff;
   entry_type         carry_ff;      // entry delayed by a split
   logic [ADDR_W-1:0] paddr_ff;
   status_type        status_ff;
   logic              rsp_valid_ff;

   entry_type cells [MAX_BLOCKS];
   entry_type nxt   [MAX_BLOCKS];
   entry_type rst_v [MAX_BLOCKS];

   entry_type         emit;
   entry_type         carry_in;
   logic              done_in;
   logic [1:0]        skip_in;
   logic [CW-1:0]     newcount_in;
   logic [ADDR_W-1:0] paddr_in;
   status_type        status_in;

   entry_type   tap0, tap1, tap2, tap_s;
   logic [CW:0] idx0, idx1, idx2, idxs, cnt_x;
   logic        ok0, ok1, ok2, oks;
   logic        hit0, hit1;

   genvar g;
   generate
      for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
         assign rst_v[g] = (g == 0) ? INIT_ENTRY : '0;
         if (g == MAX_BLOCKS - 1) begin : g_last
            assign nxt[g] = emit;
         end else begin : g_mid
            assign nxt[g] = cells[g + 1];
         end
         ffha_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .load_reset(1'b0),
            .reset_val (rst_v[g]),
            .shift_in  ((state_ff == S_RUN) ? nxt[g] : cells[g]),
            .held      (cells[g])
         );
      end
      if (MAX_BLOCKS > 2) begin : g_tap2
         assign tap2 = cells[2];
      end else begin : g_no_tap2
         assign tap2 = '0;
      end
   endgenerate

   // head taps: tap0 is table index t, tap1 is t + 1, tap2 is t + 2
   assign tap0  = cells[0];
   assign tap1  = cells[1];
   assign idx0  = {1'b0, step_ff};
   assign idx1  = idx0 + 1'b1;
   assign idx2  = idx0 + 2'd2;
   assign idxs  = idx0 + {{(CW-1){1'b0}}, skip_ff};
   assign cnt_x = {1'b0, count_ff};

   always_comb begin
      case (skip_ff)
         2'd0:    tap_s = tap0;
         2'd1:    tap_s = tap1;
         default: tap_s = tap2;
      endcase
   end

   // a tap only counts while its index lies inside the old table
   assign ok0 = tap0.valid && (idx0 < cnt_x);
   assign ok1 = tap1.valid && (idx1 < cnt_x);
   assign ok2 = tap2.valid && (idx2 < cnt_x);
   assign oks = tap_s.valid && (idxs < cnt_x);

   assign hit0 = ({1'b0, tap0.start} + (ADDR_W+1)'(HEADER_BYTES)) == {1'b0, faddr_ff};
   assign hit1 = ({1'b0, tap1.start} + (ADDR_W+1)'(HEADER_BYTES)) == {1'b0, faddr_ff};

   always_comb begin
      emit        = '0;
      carry_in    = carry_ff;
      done_in     = done_ff;
      skip_in     = skip_ff;
      newcount_in = newcount_ff;
      paddr_in    = paddr_ff;
      status_in   = status_ff;
      if (op_ff == REQ_ALLOC) begin
         if (carry_ff.valid) begin
            // delayed entry goes out; an empty slot ends the delay
            emit     = carry_ff;
            carry_in = ok0 ? tap0 : '0;
         end else if (!done_ff && ok0 && !tap0.used && {1'b0, tap0.size} > need_ff) begin
            done_in   = 1'b1;
            status_in = ST_OK;
            paddr_in  = tap0.start + ADDR_W'(HEADER_BYTES);
            emit      = tap0;
            emit.used = 1'b1;
            // spare of one header or less, or a full table: whole block
            if ({1'b0, tap0.size} > need_ff + HDR && count_ff < FULL) begin
               emit.size      = need_ff[SIZE_W-1:0];
               carry_in.valid = 1'b1;
               carry_in.used  = 1'b0;
               carry_in.start = tap0.start + need_ff[ADDR_W-1:0];
               carry_in.size  = tap0.size - need_ff[SIZE_W-1:0];
               newcount_in    = count_ff + 1'b1;
            end
         end else if (ok0) begin
            emit = tap0;
         end
      end else begin
         if (done_ff) begin
            if (oks) emit = tap_s;
         end else if (ok0 && tap0.used && hit0) begin
            // freed block with a used or no predecessor
            done_in   = 1'b1;
            status_in = ST_OK;
            emit      = tap0;
            emit.used = 1'b0;
            if (ok1 && !tap1.used) begin
               emit.size   = tap0.size + tap1.size;
               skip_in     = 2'd1;
               newcount_in = count_ff - 1'b1;
            end
         end else if (ok0 && !tap0.used && ok1 && tap1.used && hit1) begin
            // free predecessor absorbs the freed block, then a free successor
            done_in     = 1'b1;
            status_in   = ST_OK;
            emit        = tap0;
            emit.size   = tap0.size + tap1.size;
            skip_in     = 2'd1;
            newcount_in = count_ff - 1'b1;
            if (ok2 && !tap2.used) begin
               emit.size   = tap0.size + tap1.size + tap2.size;
               skip_in     = 2'd2;
               newcount_in = count_ff - 2'd2;
            end
         end else if (ok0) begin
            emit = tap0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CW'(1);
         newcount_ff  <= CW'(1);
         op_ff        <= REQ_ALLOC;
         need_ff      <= '0;
         faddr_ff     <= '0;
         done_ff      <= 1'b0;
         skip_ff      <= '0;
         step_ff      <= '0;
         carry_ff     <= '0;
         paddr_ff     <= '0;
         status_ff    <= ST_OK;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff       <= req_req_type;
                  need_ff     <= {1'b0, req_alloc_size} + HDR;
                  faddr_ff    <= req_free_addr;
                  done_ff     <= 1'b0;
                  skip_ff     <= '0;
                  step_ff     <= '0;
                  carry_ff    <= '0;
                  newcount_ff <= count_ff;
                  paddr_ff    <= '0;
                  if (req_req_type == REQ_ALLOC && req_alloc_size == '0) begin
                     status_ff    <= ST_ZERO;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_DONE;
                  end else begin
                     status_ff    <= (req_req_type == REQ_FREE) ? ST_BAD_FREE : ST_NO_FIT;
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= S_RUN;
                  end
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_RUN: begin
               carry_ff    <= carry_in;
               done_ff     <= done_in;
               skip_ff     <= skip_in;
               paddr_ff    <= paddr_in;
               status_ff   <= status_in;
               newcount_ff <= newcount_in;
               step_ff     <= step_ff + 1'b1;
               if (step_ff == LAST) begin
                  count_ff     <= newcount_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_DONE;
               end else begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_addr = (status_ff == ST_OK) ? paddr_ff : '0;
   assign rsp_status       = status_ff;

`ifndef ASSERT_OFF
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("double response");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL && count_ff != '0) else $error("count out of range");
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_payload_addr == '0)
      else $error("address on error");
`endif
endmodule

// ===== tb/first_fit_heap_allocator_test.sv =====
// Testbench for first_fit_heap_allocator: directed and random alloc/free words,
// checked against an in-bench table model. Depends on ffha_pkg and the RTL top.
`timescale 1ns / 100ps

module first_fit_heap_allocator_test
   import ffha_pkg::*;
;
   localparam int NBLK = 64;
   localparam int HDR  = 16;
   localparam int HEAP = 33554432;

   // scoreboard: own copy of the block table, queue of expected replies
   class heap_scoreboard;
      logic [ADDR_W-1:0] blk_start [NBLK];
      logic [SIZE_W:0]   blk_size  [NBLK];
      bit                blk_used  [NBLK];
      int                blk_count;
      logic [ADDR_W-1:0] exp_addr [$];
      status_type        exp_stat [$];
      int                errors;
      int                checked;

      function void clear_table();
         for (int i = 0; i < NBLK; i++) begin
            blk_start[i] = '0; blk_size[i] = '0; blk_used[i] = 0;
         end
         blk_size[0] = (SIZE_W+1)'(HEAP);
         blk_count = 1;
      endfunction

      function void drop_entry(int idx);
         for (int i = idx; i + 1 < blk_count; i++) begin
            blk_start[i] = blk_start[i+1];
            blk_size[i]  = blk_size[i+1];
            blk_used[i]  = blk_used[i+1];
         end
         blk_count--;
         blk_start[blk_count] = '0; blk_size[blk_count] = '0; blk_used[blk_count] = 0;
      endfunction

      function void add_entry(int idx, longint st, longint sz);
         for (int i = blk_count; i > idx; i--) begin
            blk_start[i] = blk_start[i-1];
            blk_size[i]  = blk_size[i-1];
            blk_used[i]  = blk_used[i-1];
         end
         blk_start[idx] = ADDR_W'(st); blk_size[idx] = (SIZE_W+1)'(sz); blk_used[idx] = 0;
         blk_count++;
      endfunction

      // note an accepted request word and predict its reply
      function void note_request(logic typ, logic [SIZE_W-1:0] sz,
                                 logic [ADDR_W-1:0] fa);
         longint need, bs;
         int i;
         logic [ADDR_W-1:0] a;
         status_type s;
         a = '0;
         s = ST_OK;
         if (typ == REQ_ALLOC) begin
            need = longint'(sz) + HDR;
            if (sz == 0) s = ST_ZERO;
            else begin
               s = ST_NO_FIT;
               for (i = 0; i < blk_count; i++) begin
                  bs = blk_size[i];
                  if (!blk_used[i] && bs > need) begin
                     blk_used[i] = 1;
                     if (bs > need + HDR && blk_count < NBLK) begin
                        blk_size[i] = (SIZE_W+1)'(need);
                        add_entry(i + 1, longint'(blk_start[i]) + need, bs - need);
                     end
                     a = ADDR_W'(blk_start[i] + HDR);
                     s = ST_OK;
                     break;
                  end
               end
            end
         end else begin
            for (i = 0; i < blk_count; i++)
               if (longint'(blk_start[i]) + HDR == longint'(fa)) break;
            if (i >= blk_count || !blk_used[i]) s = ST_BAD_FREE;
            else begin
               blk_used[i] = 0;
               if (i > 0 && !blk_used[i-1]) begin
                  blk_size[i-1] = (blk_size[i-1] + blk_size[i]) & 27'h3FFFFFF;
                  drop_entry(i);
                  i--;
               end
               if (i + 1 < blk_count && !blk_used[i+1]) begin
                  blk_size[i] = (blk_size[i] + blk_size[i+1]) & 27'h3FFFFFF;
                  drop_entry(i + 1);
               end
            end
         end
         exp_addr.push_back(a);
         exp_stat.push_back(s);
      endfunction

      function void check_reply(logic [ADDR_W-1:0] a, logic [1:0] s);
         if (exp_stat.size() == 0) begin
            $error("reply with nothing expected: addr %0d status %0d", a, s);
            errors++;
            return;
         end
         checked++;
         if (a !== exp_addr[0]) begin
            $error("payload_addr: expected %0d actual %0d", exp_addr[0], a);
            errors++;
         end
         if (s !== exp_stat[0]) begin
            $error("status: expected %0d actual %0d", exp_stat[0], s);
            errors++;
         end
         void'(exp_addr.pop_front());
         void'(exp_stat.pop_front());
      endfunction

      // payload address of a random used block, or a junk address if none
      function logic [ADDR_W-1:0] pick_used();
         int idx [$];
         for (int i = 0; i < blk_count; i++) if (blk_used[i]) idx.push_back(i);
         if (idx.size() == 0) return ADDR_W'($urandom);
         return ADDR_W'(blk_start[idx[$urandom_range(0, idx.size()-1)]] + HDR);
      endfunction
   endclass

   logic              clock, reset, start, busy;
   logic              req_req_type;
   logic [SIZE_W-1:0] req_alloc_size;
   logic [ADDR_W-1:0] req_free_addr;
   logic              rsp_valid;
   logic [ADDR_W-1:0] rsp_payload_addr;
   logic [1:0]        rsp_status;

   heap_scoreboard heap_sb;
   int idle_pct;
   int words_sent;

   first_fit_heap_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_req_type(req_req_type), .req_alloc_size(req_alloc_size),
      .req_free_addr(req_free_addr), .rsp_valid(rsp_valid),
      .rsp_payload_addr(rsp_payload_addr), .rsp_status(rsp_status)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // replies cannot be held off, so just sample on every edge
   always @(posedge clock) begin
      if (!reset && rsp_valid) heap_sb.check_reply(rsp_payload_addr, rsp_status);
   end

   // present one word; start stays high until an edge with busy low takes it
   task automatic send_word(logic typ, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] fa);
      bit taken;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_req_type   <= typ;
      req_alloc_size <= sz;
      req_free_addr  <= fa;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         if (!busy) begin
            taken = 1;
            heap_sb.note_request(typ, sz, fa);
         end
      end
      words_sent++;
   endtask

   // mostly small sizes, occasionally big or extreme
   function automatic logic [SIZE_W-1:0] rand_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return SIZE_W'($urandom_range(1, 4096));
      if (r < 90) return SIZE_W'($urandom_range(1, 1 << 20));
      if (r < 95) return SIZE_W'($urandom);
      return $urandom_range(0, 1) ? 26'd0 : 26'h3FFFFFF;
   endfunction

   task automatic random_phase(int n, int pct);
      int r;
      idle_pct = pct;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 50) send_word(REQ_ALLOC, rand_size(), ADDR_W'($urandom));
         else if (r < 88) send_word(REQ_FREE, SIZE_W'($urandom), heap_sb.pick_used());
         else if (r < 95) send_word(REQ_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
         else send_word(REQ_FREE, SIZE_W'($urandom), heap_sb.pick_used() + 1'b1);
      end
   endtask

   initial begin
      int waited;
      heap_sb = new();
      heap_sb.clear_table();
      start = 0; req_req_type = 0; req_alloc_size = '0; req_free_addr = '0;
      reset = 1; idle_pct = 0; words_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero size, exact fit edges, bad frees, merges, extremes
      send_word(REQ_ALLOC, 26'd0, '0);
      send_word(REQ_ALLOC, 26'h3FFFFFF, '0);                // no fit
      send_word(REQ_ALLOC, 26'd33554416, '0);               // size == need, no fit
      send_word(REQ_ALLOC, 26'd33554415, '0);               // whole heap given
      send_word(REQ_FREE, '0, 25'd16);
      send_word(REQ_ALLOC, 26'd100, '0);
      send_word(REQ_ALLOC, 26'd200, '0);
      send_word(REQ_ALLOC, 26'd300, '0);
      send_word(REQ_FREE, '0, 25'd17);                      // inside a block
      send_word(REQ_FREE, '0, 25'h1FFFFFF);                 // out of range
      send_word(REQ_FREE, '0, 25'd0);
      send_word(REQ_FREE, '0, 25'd132);                     // middle block
      send_word(REQ_FREE, '0, 25'd132);                     // double free
      send_word(REQ_FREE, '0, 25'd16);                      // merge with next
      send_word(REQ_ALLOC, 26'd316, '0);                    // block size == need: skipped, later block split
      send_word(REQ_FREE, '0, heap_sb.pick_used());
      send_word(REQ_FREE, '0, heap_sb.pick_used());
      // fill the table to exercise the no-split-when-full path
      for (int k = 0; k < 66; k++) send_word(REQ_ALLOC, 26'd1, '0);
      send_word(REQ_ALLOC, 26'd5000, '0);

      random_phase(250, 0);
      random_phase(250, 75);
      random_phase(250, 0);
      random_phase(250, 32);
      start <= 1'b0;

      waited = 0;
      while (heap_sb.exp_stat.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (NBLK + 10) @(posedge clock);
      $display("Sent %0d request words (alloc/free, fits, splits, merges, bad frees),",
               words_sent);
      $display("checked %0d replies, %0d mismatches.", heap_sb.checked, heap_sb.errors);
      if (heap_sb.errors == 0 && heap_sb.exp_stat.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== first_fit_heap_allocator.f =====
rtl/ffha_pkg.sv
rtl/ffha_cell.sv
rtl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_test.sv
